>>> src/tbts_pkg.sv
// Shared constants and helpers for the three-band tone stack.
// Holds coefficients, register indexes and operand-width helpers.
// No dependencies; imported by every module of the block.
`default_nettype none

package tbts_pkg;

   // Default sample width (signed Q1.(SAMPLE_BITS-1) samples)
   localparam int SAMPLE_BITS_DEFAULT = 24;

   // One-pole coefficients, unsigned Q0.24
   localparam int COEF_FRAC   = 24;
   localparam int COEF_BASS   = 540142;    // 0.032195
   localparam int COEF_TREBLE = 4692168;   // 0.279675
   localparam int COEF_GAIN   = 33554;     // 0.002

   // Gain targets are unsigned Q3.13
   localparam int TARGET_BITS = 16;
   localparam int TARGET_FRAC = 13;
   localparam logic [TARGET_BITS-1:0] TARGET_RESET = 16'd8192;

   // Configuration port
   localparam int CSR_INDEX_BITS = 8;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BASS_GAIN_TARGET   = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MID_GAIN_TARGET    = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TREBLE_GAIN_TARGET = 8'd2;

   // Width of the multiplier's second operand: wide enough for a gain
   // (sample width plus sign) and for a Q0.24 coefficient plus sign.
   function automatic int opb_bits(input int sample_bits);
      int w;
      w = sample_bits + 1;
      if (w < COEF_FRAC + 1) begin
         w = COEF_FRAC + 1;
      end
      return w;
   endfunction

endpackage

`default_nettype wire

>>> src/tbts_mul_unit.sv
// Shared signed multiplier with registered product and round-half-up shift.
// Rounds by the coefficient fraction or by the internal fraction bits.
// Depends on tbts_pkg.
`default_nettype none

module tbts_mul_unit
   import tbts_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int OPB_BITS    = opb_bits(SAMPLE_BITS)
) (
   input  wire logic                          clock,
   input  wire logic signed [SAMPLE_BITS:0]   opa,
   input  wire logic signed [OPB_BITS-1:0]    opb,
   input  wire logic                          coef_scale,
   output logic signed [SAMPLE_BITS+1:0]      rnd
);

   localparam int FB = SAMPLE_BITS - 3;
   localparam int PW = SAMPLE_BITS + 1 + OPB_BITS;
   localparam logic signed [PW-1:0] HALF_C = {{(PW-1){1'b0}}, 1'b1} << (COEF_FRAC - 1);
   localparam logic signed [PW-1:0] HALF_F = {{(PW-1){1'b0}}, 1'b1} << (FB - 1);

   logic signed [PW-1:0] prod_in;
   logic signed [PW-1:0] prod_ff;
   logic                 scale_ff;
   logic signed [PW-1:0] biased;
   logic signed [PW-1:0] shifted;

   assign prod_in = opa * opb;

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      scale_ff <= coef_scale;
   end

   // Round half up: add half an LSB of the result, then floor-shift
   assign biased  = prod_ff + (scale_ff ? HALF_C : HALF_F);
   assign shifted = scale_ff ? (biased >>> COEF_FRAC) : (biased >>> FB);
   assign rnd     = shifted[SAMPLE_BITS+1:0];

endmodule

`default_nettype wire

>>> src/three_band_tone_stack_top.sv
// Three-band tone stack top: one request in, one equalized sample out.
// A request is taken only while idle: after an entry step it runs eight passes of the
// single shared multiplier plus drain and output steps before the next is accepted; the
// output step waits while rsp_stall holds the previous result.
// Reset (synchronous, active high): filter levels clear, current gains load 1.0, targets
// load 1.0, output register empties. Depends on tbts_pkg and tbts_mul_unit.
`default_nettype none

module three_band_tone_stack_top
   import tbts_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_in,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample_out,
   // configuration write channel
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [TARGET_BITS-1:0]        csr_wdata
);

   localparam int SB        = SAMPLE_BITS;
   localparam int FB        = SB - 3;
   localparam int TGT_SHIFT = FB - TARGET_FRAC;
   localparam int OPB       = opb_bits(SB);

   localparam logic [SB-1:0]     GAIN_ONE = {{(SB-1){1'b0}}, 1'b1} << FB;
   localparam logic signed [OPB-1:0] B_COEF_BASS   = OPB'(COEF_BASS);
   localparam logic signed [OPB-1:0] B_COEF_TREBLE = OPB'(COEF_TREBLE);
   localparam logic signed [OPB-1:0] B_COEF_GAIN   = OPB'(COEF_GAIN);
   localparam logic signed [SB+4:0]  SAT_HI = {{6{1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [SB+4:0]  SAT_LO = {{6{1'b1}}, {(SB-1){1'b0}}};
   localparam logic [3:0] LAST_STEP = 4'd8;

   // Sequencer: WORK walks steps 0..8. Step k (0..7) issues operation k to the
   // multiplier; step k+1 writes its rounded result back.
   //   op 0: low level update     op 1: upper split update
   //   op 2..4: bass/mid/treble gain glide toward target
   //   op 5..7: low, mid and high band times their new gain, accumulated
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WORK,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic [3:0] step_ff;

   // request and filter state
   logic signed [SB-1:0] x_ff, x_in;
   logic signed [SB-1:0] low_ff;
   logic signed [SB-1:0] up_ff;
   logic [SB-1:0]        bass_gain_ff;
   logic [SB-1:0]        mid_gain_ff;
   logic [SB-1:0]        treble_gain_ff;
   logic [TARGET_BITS-1:0] bass_tgt_ff;
   logic [TARGET_BITS-1:0] mid_tgt_ff;
   logic [TARGET_BITS-1:0] treble_tgt_ff;
   logic signed [SB+2:0] acc_ff;

   // result register
   logic                 rsp_valid_ff;
   logic signed [SB-1:0] rsp_sample_ff, rsp_sample_in;

   // shared multiplier operands
   logic signed [SB:0]    opa;
   logic signed [OPB-1:0] opb;
   logic                  coef_scale;
   logic signed [SB+1:0]  rnd;
   logic [2:0]            issue_op;
   logic [3:0]            wb_step;
   logic [2:0]            wb_op;
   logic                  accept;
   logic                  out_free;
   logic signed [SB+2:0]  rnd_ext;
   logic signed [SB+4:0]  sum4;

   // widened operands
   logic signed [SB:0] x_w, low_w, up_w;
   logic signed [SB:0] bass_tgt_w, mid_tgt_w, treble_tgt_w;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Scale Q1.(SB-1) input into Q3.FB with a floor shift
   assign x_in = req_sample_in >>> 2;

   assign x_w   = {x_ff[SB-1], x_ff};
   assign low_w = {low_ff[SB-1], low_ff};
   assign up_w  = {up_ff[SB-1], up_ff};
   assign bass_tgt_w   = signed'({{(SB+1-TARGET_BITS){1'b0}}, bass_tgt_ff}) << TGT_SHIFT;
   assign mid_tgt_w    = signed'({{(SB+1-TARGET_BITS){1'b0}}, mid_tgt_ff}) << TGT_SHIFT;
   assign treble_tgt_w = signed'({{(SB+1-TARGET_BITS){1'b0}}, treble_tgt_ff}) << TGT_SHIFT;

   // Operand select for the operation issued this step
   assign issue_op = step_ff[2:0];
   always_comb begin
      unique case (issue_op)
         3'd0: begin
            opa = x_w - low_w;
            opb = B_COEF_BASS;
            coef_scale = 1'b1;
         end
         3'd1: begin
            opa = x_w - up_w;
            opb = B_COEF_TREBLE;
            coef_scale = 1'b1;
         end
         3'd2: begin
            opa = bass_tgt_w - signed'({1'b0, bass_gain_ff});
            opb = B_COEF_GAIN;
            coef_scale = 1'b1;
         end
         3'd3: begin
            opa = mid_tgt_w - signed'({1'b0, mid_gain_ff});
            opb = B_COEF_GAIN;
            coef_scale = 1'b1;
         end
         3'd4: begin
            opa = treble_tgt_w - signed'({1'b0, treble_gain_ff});
            opb = B_COEF_GAIN;
            coef_scale = 1'b1;
         end
         3'd5: begin
            opa = low_w;
            opb = signed'({{(OPB-SB){1'b0}}, bass_gain_ff});
            coef_scale = 1'b0;
         end
         3'd6: begin
            opa = up_w - low_w;
            opb = signed'({{(OPB-SB){1'b0}}, mid_gain_ff});
            coef_scale = 1'b0;
         end
         3'd7: begin
            opa = x_w - up_w;
            opb = signed'({{(OPB-SB){1'b0}}, treble_gain_ff});
            coef_scale = 1'b0;
         end
         default: begin
            opa = '0;
            opb = '0;
            coef_scale = 1'b0;
         end
      endcase
   end

   tbts_mul_unit #(
      .SAMPLE_BITS (SB),
      .OPB_BITS    (OPB)
   ) u_mul (
      .clock      (clock),
      .opa        (opa),
      .opb        (opb),
      .coef_scale (coef_scale),
      .rnd        (rnd)
   );

   assign wb_step = step_ff - 4'd1;
   assign wb_op   = wb_step[2:0];
   assign rnd_ext = {rnd[SB+1], rnd};

   // Output: sum times 4, saturated to the sample range
   assign sum4 = {acc_ff, 2'b00};
   always_comb begin
      priority if (sum4 > SAT_HI) begin
         rsp_sample_in = SAT_HI[SB-1:0];
      end else if (sum4 < SAT_LO) begin
         rsp_sample_in = SAT_LO[SB-1:0];
      end else begin
         rsp_sample_in = sum4[SB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         low_ff         <= '0;
         up_ff          <= '0;
         bass_gain_ff   <= GAIN_ONE;
         mid_gain_ff    <= GAIN_ONE;
         treble_gain_ff <= GAIN_ONE;
         bass_tgt_ff    <= TARGET_RESET;
         mid_tgt_ff     <= TARGET_RESET;
         treble_tgt_ff  <= TARGET_RESET;
      end else begin
         // Register writes; indexes past the list are dropped
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_BASS_GAIN_TARGET:   bass_tgt_ff   <= csr_wdata;
               REG_MID_GAIN_TARGET:    mid_tgt_ff    <= csr_wdata;
               REG_TREBLE_GAIN_TARGET: treble_tgt_ff <= csr_wdata;
               default: ;
            endcase
         end

         // Drop the result once taken, unless a new one replaces it this cycle
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  x_ff     <= x_in;
                  step_ff  <= '0;
                  state_ff <= ST_WORK;
               end
            end
            ST_WORK: begin
               // Write back the operation issued on the previous step
               if (step_ff != 4'd0) begin
                  unique case (wb_op)
                     3'd0: low_ff         <= low_ff + rnd[SB-1:0];
                     3'd1: up_ff          <= up_ff + rnd[SB-1:0];
                     3'd2: bass_gain_ff   <= bass_gain_ff + rnd[SB-1:0];
                     3'd3: mid_gain_ff    <= mid_gain_ff + rnd[SB-1:0];
                     3'd4: treble_gain_ff <= treble_gain_ff + rnd[SB-1:0];
                     3'd5: acc_ff         <= rnd_ext;
                     3'd6: acc_ff         <= acc_ff + rnd_ext;
                     3'd7: acc_ff         <= acc_ff + rnd_ext;
                     default: ;
                  endcase
               end
               if (step_ff == LAST_STEP) begin
                  state_ff <= ST_DONE;
               end else begin
                  step_ff <= step_ff + 4'd1;
               end
            end
            ST_DONE: begin
               // Hold until the result register is free
               if (out_free) begin
                  rsp_sample_ff <= rsp_sample_in;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // A new result appears only after the sequencer finished its passes
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised without a finished request");

   // An accepted request starts the sequence at its first step
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_WORK && step_ff == 4'd0))
      else $error("accepted request did not start the sequence");

   // The step counter never runs past the last writeback
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WORK) |-> (step_ff <= LAST_STEP))
      else $error("step counter out of range");

   // A pending result is never overwritten while stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_sample_ff)))
      else $error("stalled result changed");

endmodule

`default_nettype wire
